// ----- rtl/qrs_pkg.sv -----
// Package for the quadratic root solver: widths, root kind codes and the side struct.
// Used by every module of the block; depends on nothing.
package qrs_pkg;
    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_WIDTH  = 40;
    // d = b*b - 4ac needs 2*COEF_WIDTH+2 bits signed.
    localparam int DISC_WIDTH = 2 * COEF_WIDTH + 2;
    // Magnitude of d fits in DISC_WIDTH-1 bits; root has half of that, rounded up.
    localparam int SQRT_WIDTH = (DISC_WIDTH - 1 + 1) / 2;
    localparam int SQRT_STEPS = SQRT_WIDTH;
    // Numerator -b +/- s, shifted by FRAC_BITS.
    localparam int NUM_WIDTH  = COEF_WIDTH + 2;
    localparam int DIV_WIDTH  = NUM_WIDTH + FRAC_BITS;
    localparam int DEN_WIDTH  = COEF_WIDTH + 1;

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_DEGEN    = 2'd3
    } t_kind;

    // Carried alongside the square root unit.
    typedef struct packed {
        t_kind                          kind;
        logic signed [COEF_WIDTH-1:0]   b;
        logic signed [DEN_WIDTH-1:0]    den;
    } t_side;
endpackage

// ----- rtl/quadratic_root_solver_unit.sv -----
// Top level of the quadratic root solver: discriminant, square root and divide pipeline.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
// The block takes one coefficient triple per cycle (busy is always low) and returns
// one item per triple, in order. An item passes the product register and the
// discriminant register, the square root pipeline (SQRT_STEPS stages, one per root
// bit), one stage to form the numerators, and the two parallel divider pipelines
// (DIV_WIDTH stages, one per quotient bit), then the output register. The result is
// shown for one cycle with o_valid; the receiver cannot stall, so nothing inside the
// block ever waits.
module quadratic_root_solver_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  i_coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  i_coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  i_coef_c,
    output logic                                   o_valid,
    output logic [1:0]                             o_root_kind,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0]   o_first_value,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0]   o_second_value
);
    localparam int CW = qrs_pkg::COEF_WIDTH;
    localparam int DW = qrs_pkg::DISC_WIDTH;
    localparam int SW = qrs_pkg::SQRT_WIDTH;
    localparam int NW = qrs_pkg::NUM_WIDTH;

    assign busy = 1'b0;

    // Stage 1: the two products, each in its own multiplier.
    logic signed [2*CW-1:0] n_bb, n_ac;
    always_comb begin
        n_bb = i_coef_b * i_coef_b;
        n_ac = i_coef_a * i_coef_c;
    end

    logic                   r1_v;
    logic signed [DW-1:0]   r1_bb, r1_ac;
    logic signed [CW-1:0]   r1_a, r1_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start;
        end
        r1_bb <= DW'(n_bb);
        r1_ac <= DW'(n_ac);
        r1_a  <= i_coef_a;
        r1_b  <= i_coef_b;
    end

    // Stage 2: the discriminant; a zero a, its sign or its being zero picks the case; the magnitude goes to the root.
    logic signed [DW-1:0] n_d;
    qrs_pkg::t_side n_side;
    logic [DW-2:0] n_mag;
    always_comb begin
        n_d = r1_bb - (r1_ac <<< 2);
        n_mag = n_d[DW-1] ? (DW-1)'(-n_d) : n_d[DW-2:0];
        if (r1_a == '0) begin
            n_side.kind = qrs_pkg::KIND_DEGEN;
        end else if (n_d[DW-1]) begin
            n_side.kind = qrs_pkg::KIND_COMPLEX;
        end else if (n_d == '0) begin
            n_side.kind = qrs_pkg::KIND_DOUBLE;
        end else begin
            n_side.kind = qrs_pkg::KIND_DISTINCT;
        end
        n_side.b   = r1_b;
        n_side.den = {r1_a, 1'b0};
    end

    logic                 r2_v;
    logic [DW-2:0]        r2_mag;
    qrs_pkg::t_side       r2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_mag  <= n_mag;
        r2_side <= n_side;
    end

    logic            sq_v;
    logic [SW-1:0]   sq_root;
    qrs_pkg::t_side  sq_side;
    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_mag   (r2_mag),
        .i_side  (r2_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Numerators for the two quotients.
    logic                 r3_v;
    logic signed [NW-1:0] r3_n1, r3_n2;
    qrs_pkg::t_side       r3_side;
    logic signed [NW-1:0] n_nb, n_s;
    always_comb begin
        n_nb = -NW'(sq_side.b);
        n_s  = NW'($signed({1'b0, sq_root}));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= sq_v;
        end
        r3_side <= sq_side;
        case (sq_side.kind)
            qrs_pkg::KIND_DISTINCT: begin
                r3_n1 <= n_nb + n_s;
                r3_n2 <= n_nb - n_s;
            end
            qrs_pkg::KIND_COMPLEX: begin
                r3_n1 <= n_nb;
                r3_n2 <= n_s;
            end
            default: begin
                r3_n1 <= n_nb;
                r3_n2 <= n_nb;
            end
        endcase
    end

    logic                                 d1_v, d2_v;
    logic signed [qrs_pkg::OUT_WIDTH-1:0] d1_q, d2_q;
    logic signed [qrs_pkg::DEN_WIDTH-1:0] n_den;
    // A zero divisor only comes with a degenerate item, whose quotients are dropped.
    assign n_den = (r3_side.kind == qrs_pkg::KIND_DEGEN) ? qrs_pkg::DEN_WIDTH'(1) : r3_side.den;

    qrs_div u_div1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r3_v),
        .i_num (r3_n1), .i_den (n_den), .o_valid (d1_v), .o_quot (d1_q)
    );
    qrs_div u_div2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r3_v),
        .i_num (r3_n2), .i_den (n_den), .o_valid (d2_v), .o_quot (d2_q)
    );

    // The kind rides a delay line matched to the divider depth.
    localparam int DL = qrs_pkg::DIV_WIDTH;
    qrs_pkg::t_kind r_kind [DL];
    always_ff @(posedge i_clk) begin
        r_kind[0] <= r3_side.kind;
        for (int k = 1; k < DL; k++) begin
            r_kind[k] <= r_kind[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= d1_v;
        end
        o_root_kind <= r_kind[DL-1];
        if (r_kind[DL-1] == qrs_pkg::KIND_DEGEN) begin
            o_first_value  <= '0;
            o_second_value <= '0;
        end else begin
            o_first_value  <= d1_q;
            o_second_value <= d2_q;
        end
    end

`ifndef SYNTHESIS
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n) d1_v == d2_v)
        else $error("divider lanes out of step");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KIND_DEGEN) |->
        (o_first_value == '0 && o_second_value == '0))
        else $error("degenerate item with nonzero value");
    a_double_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KIND_DOUBLE) |-> o_first_value == o_second_value)
        else $error("double root values differ");
`endif
endmodule

// ----- rtl/qrs_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [qrs_pkg::DISC_WIDTH-2:0]       i_mag,
    input  qrs_pkg::t_side                       i_side,
    output logic                                 o_valid,
    output logic [qrs_pkg::SQRT_WIDTH-1:0]       o_root,
    output qrs_pkg::t_side                       o_side
);
    localparam int N  = qrs_pkg::SQRT_STEPS;
    localparam int RW = 2 * N + 2;

    logic                 r_v   [1:N];
    logic [2*N-1:0]       r_rem [1:N];
    logic [N-1:0]         r_q   [1:N];
    logic [RW-1:0]        r_acc [1:N];
    qrs_pkg::t_side       r_sd  [1:N];

    // Restoring method: each stage brings in two bits of the radicand.
    for (genvar k = 0; k < N; k++) begin : g_st
        logic                 n_v;
        logic [2*N-1:0]       n_rem;
        logic [N-1:0]         n_q;
        logic [RW-1:0]        n_prev;
        qrs_pkg::t_side       n_sd;
        logic [RW-1:0]        n_acc, n_try;
        if (k == 0) begin : g_src
            // The first stage takes the item straight from the inputs.
            assign n_v    = i_valid;
            assign n_rem  = {{(2*N-(qrs_pkg::DISC_WIDTH-1)){1'b0}}, i_mag};
            assign n_q    = '0;
            assign n_prev = '0;
            assign n_sd   = i_side;
        end else begin : g_src
            assign n_v    = r_v[k];
            assign n_rem  = r_rem[k];
            assign n_q    = r_q[k];
            assign n_prev = r_acc[k];
            assign n_sd   = r_sd[k];
        end
        always_comb begin
            n_acc = {n_prev[RW-3:0], n_rem[2*N-1 -: 2]};
            n_try = n_acc - {{(RW-N-2){1'b0}}, n_q, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= n_v;
            end
            r_rem[k+1] <= {n_rem[2*N-3:0], 2'b00};
            r_sd[k+1]  <= n_sd;
            if (!n_try[RW-1]) begin
                r_acc[k+1] <= n_try;
                r_q[k+1]   <= {n_q[N-2:0], 1'b1};
            end else begin
                r_acc[k+1] <= n_acc;
                r_q[k+1]   <= {n_q[N-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_q[N];
    assign o_side  = r_sd[N];
endmodule

// ----- rtl/qrs_div.sv -----
// Pipelined signed divider, one quotient bit per stage, truncating toward zero,
// with saturation to the output range. Depends on qrs_pkg.
module qrs_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [qrs_pkg::NUM_WIDTH-1:0]   i_num,
    input  logic signed [qrs_pkg::DEN_WIDTH-1:0]   i_den,
    output logic                                   o_valid,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0]   o_quot
);
    localparam int NW = qrs_pkg::DIV_WIDTH;
    localparam int DW = qrs_pkg::DEN_WIDTH;
    localparam int OW = qrs_pkg::OUT_WIDTH;
    localparam int MW = (NW > OW) ? NW : OW;
    localparam logic [MW-1:0] POS_LIMIT = MW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [MW-1:0] NEG_LIMIT = MW'(64'd1 << (OW - 1));

    logic             r_v   [1:NW];
    logic [NW-1:0]    r_n   [1:NW];
    logic [DW:0]      r_rem [1:NW];
    logic [DW-1:0]    r_d   [1:NW];
    logic             r_neg [1:NW];

    logic [NW-1:0] n_numa;
    logic [DW-1:0] n_dena;
    logic          n_sgn;
    always_comb begin
        logic signed [NW-1:0] sn;
        sn     = {i_num, {qrs_pkg::FRAC_BITS{1'b0}}};
        n_numa = sn[NW-1] ? NW'(-sn) : sn;
        n_dena = i_den[DW-1] ? DW'(-i_den) : i_den;
        n_sgn  = sn[NW-1] ^ i_den[DW-1];
    end

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic          n_v;
        logic [NW-1:0] n_n;
        logic [DW:0]   n_rem;
        logic [DW-1:0] n_d;
        logic          n_neg;
        logic [DW:0]   n_sh, n_sub;
        if (k == 0) begin : g_src
            // The first stage takes the magnitudes formed above.
            assign n_v   = i_valid;
            assign n_n   = n_numa;
            assign n_rem = '0;
            assign n_d   = n_dena;
            assign n_neg = n_sgn;
        end else begin : g_src
            assign n_v   = r_v[k];
            assign n_n   = r_n[k];
            assign n_rem = r_rem[k];
            assign n_d   = r_d[k];
            assign n_neg = r_neg[k];
        end
        always_comb begin
            n_sh  = {n_rem[DW-1:0], n_n[NW-1]};
            n_sub = n_sh - {1'b0, n_d};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= n_v;
            end
            r_d[k+1]   <= n_d;
            r_neg[k+1] <= n_neg;
            if (!n_sub[DW]) begin
                r_rem[k+1] <= n_sub;
                r_n[k+1]   <= {n_n[NW-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_sh;
                r_n[k+1]   <= {n_n[NW-2:0], 1'b0};
            end
        end
    end

    // Sign restored here; a magnitude past the output range clamps to its end.
    logic [MW-1:0]        n_big;
    logic signed [OW-1:0] n_mag;
    always_comb begin
        n_big = MW'(r_n[NW]);
        n_mag = OW'(n_big);
        if (!r_neg[NW] && n_big > POS_LIMIT) begin
            o_quot = {1'b0, {(OW-1){1'b1}}};
        end else if (r_neg[NW] && n_big > NEG_LIMIT) begin
            o_quot = {1'b1, {(OW-1){1'b0}}};
        end else begin
            o_quot = r_neg[NW] ? -n_mag : n_mag;
        end
    end
    assign o_valid = r_v[NW];
endmodule
